// ===== sv/sha1md_pkg.sv =====
`timescale 1ns / 1ps
package sha1md_pkg;

  localparam int NUM_WORDS  = 5;
  localparam int BLOCK_BITS = 512;
  localparam int ROUNDS     = 80;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_last;
  } out_item_t;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // One classified word handed from the front queue to the engine.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // Digest hand-off from the engine to the result queue.
  typedef struct packed {
    logic                        load;
    logic [NUM_WORDS-1:0][31:0]  words;
  } dig_load_t;

  localparam logic [NUM_WORDS-1:0][31:0] H_INIT = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// ===== sv/sha1_message_digest_top.sv =====
`timescale 1ns / 1ps
// SHA-1 engine: an absorbed byte waits in the input queue, then the engine shifts it into the block.
// Each full 64-byte block runs the 80 rounds, one round per cycle, then a chaining add; the
// engine takes no new bytes from the input queue until the block is compressed and added.
// A finish writes 9 to 72 padding bytes, compresses each padded block and loads the digest,
// after which the five digest words pop out one per cycle while pop is held.
// Reset (rst, synchronous) empties both queues and restores the initial hash; no clearing pass.
module sha1_message_digest_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  sha1md_pkg::in_item_t  item,
  output logic                  empty,
  input  logic                  pop,
  output sha1md_pkg::out_item_t result
);
  import sha1md_pkg::*;

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_take;
  logic      out_busy;
  dig_load_t dig;

  sha1md_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  sha1md_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .out_busy (out_busy),
    .dig      (dig)
  );

  sha1md_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .dig   (dig),
    .busy  (out_busy),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

endmodule

// ===== sv/sha1md_front.sv =====
`timescale 1ns / 1ps
module sha1md_front #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sha1md_pkg::in_item_t item,
  output logic                cmd_valid,
  output sha1md_pkg::cmd_t    cmd,
  input  logic                cmd_take
);
  import sha1md_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == FULL_CNT);
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr].op   <= item.func ? OP_FINISH : OP_ABSORB;
      slots[wr_ptr].data <= item.data_byte;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/sha1md_core.sv =====
`timescale 1ns / 1ps
module sha1md_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  sha1md_pkg::cmd_t      cmd,
  output logic                  cmd_take,
  input  logic                  out_busy,
  output sha1md_pkg::dig_load_t dig
);
  import sha1md_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

  state_t                     state;
  logic [NUM_WORDS-1:0][31:0] h;
  logic [BLOCK_BITS-1:0]      blk;
  logic [5:0]                 fill;
  logic [63:0]                total;
  logic [63:0]                bits;
  logic                       sent80;
  logic                       lenflag;
  logic                       finishing;
  logic [6:0]                 round;
  logic [31:0]                ra, rb, rc, rd, re;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        len_byte;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] w0, w2, w8, w13, w_new;

  assign cmd_take = (state == ST_IDLE) && cmd_valid;

  // Padding emits 0x80, then zeros until byte 56, then the bit length.
  assign len_byte = sent80 && (lenflag || (fill == 6'd56));

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = cmd.data;
    if (state == ST_IDLE) begin
      wr_en = cmd_valid && (cmd.op == OP_ABSORB);
    end else if (state == ST_PAD) begin
      wr_en = 1'b1;
      if (!sent80) begin
        wr_byte = PAD_BYTE;
      end else if (len_byte) begin
        wr_byte = bits[8*(7 - fill[2:0]) +: 8];
      end else begin
        wr_byte = 8'h00;
      end
    end
  end

  assign w0    = blk[BLOCK_BITS-1    -: 32];
  assign w2    = blk[BLOCK_BITS-1-64  -: 32];
  assign w8    = blk[BLOCK_BITS-1-256 -: 32];
  assign w13   = blk[BLOCK_BITS-1-416 -: 32];
  assign w_new = {(w13 ^ w8 ^ w2 ^ w0)} << 1 | {31'b0, w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

  always_comb begin
    priority if (round < 7'd20) begin
      f = (rb & rc) | (~rb & rd);
      k = K0;
    end else if (round < 7'd40) begin
      f = rb ^ rc ^ rd;
      k = K1;
    end else if (round < 7'd60) begin
      f = (rb & rc) | (rb & rd) | (rc & rd);
      k = K2;
    end else begin
      f = rb ^ rc ^ rd;
      k = K3;
    end
  end

  assign t = {ra[26:0], ra[31:27]} + f + re + k + w0;

  assign dig.load  = (state == ST_EMIT) && !out_busy;
  assign dig.words = h;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk <= {blk[BLOCK_BITS-9:0], wr_byte};
    end else if (state == ST_COMP) begin
      blk <= {blk[BLOCK_BITS-33:0], w_new};
    end
    if (rst) begin
      state     <= ST_IDLE;
      h         <= H_INIT;
      fill      <= '0;
      total     <= '0;
      bits      <= '0;
      sent80    <= 1'b0;
      lenflag   <= 1'b0;
      finishing <= 1'b0;
      round     <= '0;
    end else begin
      if (wr_en) begin
        fill <= fill + 1'b1;
        if (fill == 6'd63) begin
          state <= ST_COMP;
          round <= '0;
          ra    <= h[0];
          rb    <= h[1];
          rc    <= h[2];
          rd    <= h[3];
          re    <= h[4];
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_ABSORB) begin
              total <= total + 64'd1;
            end else begin
              bits      <= {total[60:0], 3'b000};
              total     <= '0;
              finishing <= 1'b1;
              state     <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!sent80) begin
            sent80 <= 1'b1;
          end else if (len_byte) begin
            lenflag <= 1'b1;
          end
        end
        ST_COMP: begin
          re    <= rd;
          rd    <= rc;
          rc    <= {rb[1:0], rb[31:2]};
          rb    <= ra;
          ra    <= t;
          round <= round + 1'b1;
          if (round == LAST_ROUND) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          h[0] <= h[0] + ra;
          h[1] <= h[1] + rb;
          h[2] <= h[2] + rc;
          h[3] <= h[3] + rd;
          h[4] <= h[4] + re;
          if (lenflag) begin
            state <= ST_EMIT;
          end else if (finishing) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!out_busy) begin
            h         <= H_INIT;
            sent80    <= 1'b0;
            lenflag   <= 1'b0;
            finishing <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/sha1md_outq.sv =====
`timescale 1ns / 1ps
module sha1md_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  sha1md_pkg::dig_load_t dig,
  output logic                  busy,
  output logic                  empty,
  input  logic                  pop,
  output sha1md_pkg::out_item_t result
);
  import sha1md_pkg::*;

  localparam logic [2:0] LAST_IDX = 3'(NUM_WORDS - 1);

  logic [NUM_WORDS-1:0][31:0] words;
  logic [2:0]                 idx;

  assign empty              = !busy;
  assign result.digest_word = words[0];
  assign result.word_last   = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (dig.load) begin
      words <= dig.words;
    end else if (pop && busy) begin
      words <= {32'h0, words[NUM_WORDS-1:1]};
    end
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (dig.load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (pop && busy) begin
      idx <= idx + 1'b1;
      if (idx == LAST_IDX) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/sha1_digest_checker.sv =====
`timescale 1ns / 1ps
module sha1_digest_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  sha1md_pkg::in_item_t  item,
  input  logic                  empty,
  input  logic                  pop,
  input  sha1md_pkg::out_item_t result,
  output int                    mismatches,
  output int                    words_due,
  output int                    words_checked
);
  import sha1md_pkg::*;

  logic [31:0] chain_h [NUM_WORDS];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] byte_total;
  out_item_t   digest_words_due [$];

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic void compress_block_into_chain();
    logic [31:0] w [ROUNDS];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < ROUNDS; i++) begin
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < ROUNDS; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < NUM_WORDS; i++) begin
      chain_h[i] = H_INIT[i];
    end
    block_fill = 0;
    byte_total = '0;
  endfunction

  function automatic void place_byte(input logic [7:0] v);
    msg_block[block_fill] = v;
    block_fill++;
    if (block_fill == 64) begin
      compress_block_into_chain();
      block_fill = 0;
    end
  endfunction

  // Pads the message, appends the bit length and queues the five digest words.
  function automatic void finish_message();
    logic [63:0] bit_len;
    out_item_t   w;
    bit_len = byte_total << 3;
    place_byte(PAD_BYTE);
    while (block_fill != 56) place_byte(8'h00);
    for (int i = 0; i < 8; i++) begin
      place_byte(bit_len[63-8*i -: 8]);
    end
    for (int i = 0; i < NUM_WORDS; i++) begin
      w.digest_word = chain_h[i];
      w.word_last   = (i == NUM_WORDS - 1);
      digest_words_due.push_back(w);
    end
    restart_message();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      restart_message();
      digest_words_due.delete();
      mismatches = 0;
      words_checked = 0;
      words_due <= 0;
    end else begin
      if (pop && !empty) begin
        if (digest_words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last=%b",
                                    result.digest_word, result.word_last));
        end else begin
          want = digest_words_due.pop_front();
          if (result.digest_word !== want.digest_word) begin
            report_mismatch($sformatf("digest_word: expected %h, got %h",
                                      want.digest_word, result.digest_word));
          end
          if (result.word_last !== want.word_last) begin
            report_mismatch($sformatf("word_last: expected %b, got %b",
                                      want.word_last, result.word_last));
          end
          words_checked++;
        end
      end
      if (push && !full) begin
        if (item.func == OP_FINISH) begin
          finish_message();
        end else begin
          byte_total++;
          place_byte(item.data_byte);
        end
      end
      words_due <= digest_words_due.size();
    end
  end

endmodule

// ===== dv/tb_sha1_message_digest_top.sv =====
`timescale 1ns / 1ps
module tb_sha1_message_digest_top;
  import sha1md_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int TARGET_ITEMS = 360;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;

  int mismatches;
  int words_due;
  int words_checked;

  int items_sent;
  int n_messages;
  int n_overflow;
  int n_bytes;
  int longest;
  int idle_cycles;
  int rx_stall;
  int rx_fast;

  sha1_message_digest_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  sha1_digest_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .mismatches    (mismatches),
    .words_due     (words_due),
    .words_checked (words_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: a random stall before each word, with occasional bursts of no stall.
  always @(posedge clk) begin : result_side
    int nstall;
    if (rst) begin
      pop <= 1'b0;
      rx_stall <= 0;
      rx_fast <= 0;
    end else if (pop && !empty) begin
      if (rx_fast > 0) begin
        nstall = 0;
        rx_fast <= rx_fast - 1;
      end else if ($urandom_range(0, 15) == 0) begin
        nstall = 0;
        rx_fast <= 25;
      end else begin
        nstall = $urandom_range(0, 13);
      end
      rx_stall <= nstall;
      pop <= (nstall == 0);
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      pop <= (rx_stall == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a clock edge; returns at the edge where the word is accepted.
  task automatic send_word(input op_t f, input logic [7:0] b, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{func: f, data_byte: b};
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_message(input int len, input bit burst);
    for (int i = 0; i < len; i++) begin
      send_word(OP_ABSORB, random_byte(), burst ? 0 : $urandom_range(0, 13));
    end
    send_word(OP_FINISH, 8'($urandom_range(0, 255)), burst ? 0 : $urandom_range(0, 13));
    n_messages++;
    n_bytes += len;
    if (len % 64 >= 56) n_overflow++;
    if (len > longest) longest = len;
  endtask

  initial begin
    int len;
    push <= 1'b0;
    item <= '0;
    rst <= 1'b1;
    items_sent = 0;
    n_messages = 0;
    n_overflow = 0;
    n_bytes = 0;
    longest = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, back-to-back finishes, "abc", extreme bytes.
    send_word(OP_FINISH, 8'h00, 0);
    send_word(OP_FINISH, 8'hff, 0);
    send_word(OP_ABSORB, 8'h61, 0);
    send_word(OP_ABSORB, 8'h62, 1);
    send_word(OP_ABSORB, 8'h63, 0);
    send_word(OP_FINISH, 8'h00, 3);
    send_word(OP_ABSORB, 8'h00, 0);
    send_word(OP_ABSORB, 8'hff, 0);
    send_word(OP_ABSORB, 8'h80, 2);
    send_word(OP_ABSORB, 8'h7f, 0);
    send_word(OP_FINISH, 8'hff, 0);
    n_messages += 4;
    n_bytes += 7;
    longest = 4;
    // Hold the sender until every digest word has come back.
    drain_results();

    // Random messages, with lengths clustered around the padding boundaries.
    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 12);
        4, 5, 6:    len = $urandom_range(52, 68);
        7:          len = $urandom_range(116, 130);
        8:          len = $urandom_range(13, 51);
        default:    len = $urandom_range(0, 3);
      endcase
      // Keep the total word count close to the target.
      if (len > TARGET_ITEMS - items_sent) len = TARGET_ITEMS - items_sent;
      send_message(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (200) @(posedge clk);
    $display("Sent %0d words in %0d messages (%0d bytes, longest %0d, %0d needing a padding block).",
             items_sent, n_messages, n_bytes, longest, n_overflow);
    $display("Checked %0d digest words with random stalls on both sides.", words_checked);
    if (mismatches == 0 && words_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
